FILE: hw/rtl/dual_linear_queue_shared_buffer_top_defines.svh
// Assertion macros used by the checker file of the dual queue block.
// Depends on nothing; included by bare file name where assertions are written.
`ifndef DUAL_LINEAR_QUEUE_SHARED_BUFFER_TOP_DEFINES_SVH
`define DUAL_LINEAR_QUEUE_SHARED_BUFFER_TOP_DEFINES_SVH

// Checked at every rising edge outside reset.
`define DLQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every rising edge, reset included.
`define DLQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/dlq_pkg.sv
// Package of the dual queue block: beat types, codes and size constants.
// Used by the top level, the checker and the testbench; depends on nothing.
`default_nettype none

package dlq_pkg;

  localparam int MAX_QUEUE_SIZE = 64;
  localparam int WORD_BITS      = 32;
  localparam int QSIZE_W        = 7;
  localparam int DATA_W         = 32;

  localparam logic [QSIZE_W-1:0] QSIZE_RESET = 7'd64;
  localparam logic [DATA_W-1:0]  RESULT_EMPTY = '1;

  typedef enum logic [1:0] {
    KIND_PUSH_ONE = 2'd0,
    KIND_POP_ONE  = 2'd1,
    KIND_PUSH_TWO = 2'd2,
    KIND_POP_TWO  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    status_t                  status;
  } out_beat_t;

  typedef struct packed {
    logic [QSIZE_W-1:0] queue_size;
  } cfg_beat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dlq_chan_if.sv
// Valid/ready channel interface carrying one beat of a given payload type.
// Instantiated for the input, result and configuration channels of the block.
`default_nettype none

interface dlq_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/dual_linear_queue_shared_buffer_top.sv
// Top level of the two linear queues that share one buffer.
// Depends on dlq_pkg, dlq_chan_if and dlq_ram.
//
//   channel   dir   payload                     handshake
//   in_ch     in    kind, value                 valid/ready
//   out_ch    out   result_value, status        valid/ready
//   cfg_ch    in    queue_size                  valid/ready, always ready
//
// One beat is taken per cycle while the result is not stalled; its result passes
// through the stage-one register and then the result register to out_ch.
// The pointer update and the buffer access happen at the accepting edge; the
// buffer read data is registered and then folded into the result register.
// Reset is synchronous, clears the pointers and the pipeline and sets queue_size to 64.
// When the result is stalled one more beat is taken before in_ch.ready drops.
`default_nettype none

module dual_linear_queue_shared_buffer_top #(
  parameter int MAX_QUEUE_SIZE = dlq_pkg::MAX_QUEUE_SIZE,
  parameter int WORD_BITS      = dlq_pkg::WORD_BITS
) (
  input wire logic    clk,
  input wire logic    rst_n,
  dlq_chan_if.sink    in_ch,
  dlq_chan_if.source  out_ch,
  dlq_chan_if.sink    cfg_ch
);

  localparam int BUF_DEPTH = 2 * MAX_QUEUE_SIZE;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int CMP_W     = (PTR_W > dlq_pkg::QSIZE_W) ? PTR_W : dlq_pkg::QSIZE_W;
  localparam int DW        = dlq_pkg::DATA_W;

  logic [dlq_pkg::QSIZE_W-1:0] qsize_r;
  logic [CMP_W-1:0]            qsize_ext;
  logic [PTR_W-1:0]            size_w;
  logic [PTR_W-1:0]            size_m1;
  logic [PTR_W-1:0]            top_two;

  logic [PTR_W-1:0] head1_r, head1_nxt, tail1_r, tail1_nxt;
  logic [PTR_W-1:0] head2_r, head2_nxt, tail2_r, tail2_nxt;
  logic             empty1_r, empty1_nxt, empty2_r, empty2_nxt;

  logic                 in_acc;
  logic                 in_rdy;
  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic                 ram_re;
  logic [PTR_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS+DW-1:0] word_in_ext;
  logic [WORD_BITS+DW-1:0] word_out_ext;

  dlq_pkg::status_t   st_nxt;
  logic               pop_ok_nxt;

  logic               p1_valid_r;
  dlq_pkg::status_t   p1_status_r;
  logic               p1_pop_r;
  logic               p1_adv;

  logic               out_valid_r;
  dlq_pkg::out_beat_t out_data_r;
  logic [DW-1:0]      result_nxt;

  // Configuration register.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qsize_r <= dlq_pkg::QSIZE_RESET;
    end else if (cfg_ch.valid) begin
      qsize_r <= cfg_ch.data.queue_size;
    end
  end

  // Effective size: zero acts as one, values above the buffer half are clamped.
  assign qsize_ext = CMP_W'(qsize_r);

  always_comb begin
    if (qsize_ext == '0) begin
      size_w = PTR_W'(1);
    end else if (qsize_ext > CMP_W'(MAX_QUEUE_SIZE)) begin
      size_w = PTR_W'(MAX_QUEUE_SIZE);
    end else begin
      size_w = qsize_ext[PTR_W-1:0];
    end
  end

  assign size_m1 = size_w - PTR_W'(1);
  assign top_two = PTR_W'({size_w, 1'b0} - (PTR_W + 1)'(1));

  // Handshake.
  assign p1_adv      = p1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_rdy      = !p1_valid_r || p1_adv;
  assign in_ch.ready = in_rdy;
  assign in_acc      = in_ch.valid && in_rdy;

  assign word_in_ext = {{WORD_BITS{1'b0}}, in_ch.data.value};
  assign ram_wdata   = word_in_ext[WORD_BITS-1:0];

  // Queue control for the accepted beat.
  always_comb begin
    head1_nxt  = head1_r;
    tail1_nxt  = tail1_r;
    empty1_nxt = empty1_r;
    head2_nxt  = head2_r;
    tail2_nxt  = tail2_r;
    empty2_nxt = empty2_r;
    ram_we     = 1'b0;
    ram_waddr  = tail1_r;
    ram_re     = 1'b0;
    ram_raddr  = head1_r;
    st_nxt     = dlq_pkg::ST_DONE;
    pop_ok_nxt = 1'b0;
    if (in_acc) begin
      case (in_ch.data.kind)
        dlq_pkg::KIND_PUSH_ONE: begin
          if (empty1_r) begin
            head1_nxt  = '0;
            tail1_nxt  = '0;
            empty1_nxt = 1'b0;
            ram_we     = 1'b1;
            ram_waddr  = '0;
          end else if (tail1_r >= size_m1) begin
            st_nxt = dlq_pkg::ST_FULL;
          end else begin
            tail1_nxt = tail1_r + PTR_W'(1);
            ram_we    = 1'b1;
            ram_waddr = tail1_r + PTR_W'(1);
          end
        end
        dlq_pkg::KIND_POP_ONE: begin
          if (empty1_r) begin
            st_nxt = dlq_pkg::ST_EMPTY;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = head1_r;
            pop_ok_nxt = 1'b1;
            if (head1_r == tail1_r) begin
              head1_nxt  = '0;
              tail1_nxt  = '0;
              empty1_nxt = 1'b1;
            end else begin
              head1_nxt = head1_r + PTR_W'(1);
            end
          end
        end
        dlq_pkg::KIND_PUSH_TWO: begin
          if (empty2_r) begin
            head2_nxt  = top_two;
            tail2_nxt  = top_two;
            empty2_nxt = 1'b0;
            ram_we     = 1'b1;
            ram_waddr  = top_two;
          end else if (tail2_r <= size_w) begin
            st_nxt = dlq_pkg::ST_FULL;
          end else begin
            tail2_nxt = tail2_r - PTR_W'(1);
            ram_we    = 1'b1;
            ram_waddr = tail2_r - PTR_W'(1);
          end
        end
        dlq_pkg::KIND_POP_TWO: begin
          if (empty2_r) begin
            st_nxt = dlq_pkg::ST_EMPTY;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = head2_r;
            pop_ok_nxt = 1'b1;
            if (head2_r == tail2_r) begin
              head2_nxt  = '0;
              tail2_nxt  = '0;
              empty2_nxt = 1'b1;
            end else begin
              head2_nxt = head2_r - PTR_W'(1);
            end
          end
        end
        default: begin
          st_nxt = dlq_pkg::ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head1_r  <= '0;
      tail1_r  <= '0;
      empty1_r <= 1'b1;
      head2_r  <= '0;
      tail2_r  <= '0;
      empty2_r <= 1'b1;
    end else begin
      head1_r  <= head1_nxt;
      tail1_r  <= tail1_nxt;
      empty1_r <= empty1_nxt;
      head2_r  <= head2_nxt;
      tail2_r  <= tail2_nxt;
      empty2_r <= empty2_nxt;
    end
  end

  dlq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BUF_DEPTH)
  ) u_dlq_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stage one: status of the beat while the buffer read completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (in_acc) begin
      p1_valid_r <= 1'b1;
    end else if (p1_adv) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_status_r <= st_nxt;
      p1_pop_r    <= pop_ok_nxt;
    end
  end

  // Result register.
  assign word_out_ext = {{DW{ram_rdata[WORD_BITS-1]}}, ram_rdata};

  always_comb begin
    if (p1_pop_r) begin
      result_nxt = word_out_ext[DW-1:0];
    end else if (p1_status_r == dlq_pkg::ST_EMPTY) begin
      result_nxt = dlq_pkg::RESULT_EMPTY;
    end else begin
      result_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      out_data_r.result_value <= result_nxt;
      out_data_r.status       <= p1_status_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/dlq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; holds the shared queue buffer.
`default_nettype none

module dlq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/dlq_checker.sv
// Port-level checker for the dual queue top level, attached by bind below.
// Depends on dlq_pkg and dual_linear_queue_shared_buffer_top_defines.svh.
`default_nettype none

`include "dual_linear_queue_shared_buffer_top_defines.svh"

module dlq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_result_value,
  input wire logic [1:0]  out_status
);

  logic       in_beat;
  logic       out_beat;
  logic [1:0] pending_r;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // Beats taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_beat && !out_beat) begin
      pending_r <= pending_r + 2'd1;
    end else if (out_beat && !in_beat) begin
      pending_r <= pending_r - 2'd1;
    end
  end

  `DLQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_result_value) && $stable(out_status), "result beat changed while stalled")
  `DLQ_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid right after reset")
  `DLQ_ASSERT(a_pending_cap, clk, rst_n, pending_r != 2'd3, "more beats in flight than the pipeline holds")
  `DLQ_ASSERT(a_no_orphan, clk, rst_n, out_valid |-> pending_r != 2'd0, "result beat without an accepted input beat")
  `DLQ_ASSERT(a_empty_value, clk, rst_n, out_valid && out_status == dlq_pkg::ST_EMPTY |-> out_result_value == dlq_pkg::RESULT_EMPTY, "empty pop must return all ones")

endmodule

bind dual_linear_queue_shared_buffer_top dlq_checker u_dlq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_value (out_ch.data.result_value),
  .out_status       (out_ch.data.status)
);

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the two linear queues that share one buffer.
// Depends on dlq_pkg, dlq_chan_if and dual_linear_queue_shared_buffer_top.
// A scoreboard class predicts each result beat; tasks drive pushes, pops and sizes.

import dlq_pkg::*;

class dlq_scoreboard;
  logic [DATA_W-1:0]  words [2*MAX_QUEUE_SIZE];
  int unsigned        head_one, tail_one, head_two, tail_two;
  bit                 empty_one, empty_two;
  logic [QSIZE_W-1:0] qsize;
  out_beat_t          pending_results[$];
  int                 mismatches;

  function new();
    foreach (words[i]) words[i] = '0;
    head_one = 0;
    tail_one = 0;
    head_two = 0;
    tail_two = 0;
    empty_one = 1'b1;
    empty_two = 1'b1;
    qsize = QSIZE_RESET;
    mismatches = 0;
  endfunction

  function void note_op(in_beat_t op);
    int unsigned cap;
    out_beat_t   res;
    cap = (qsize == 0) ? 1 : (qsize > MAX_QUEUE_SIZE) ? MAX_QUEUE_SIZE : qsize;
    res.result_value = '0;
    res.status = ST_DONE;
    case (op.kind)
      KIND_PUSH_ONE: begin
        if (empty_one) begin
          head_one = 0;
          tail_one = 0;
          empty_one = 1'b0;
          words[0] = op.value;
        end else if (tail_one >= cap - 1) begin
          res.status = ST_FULL;
        end else begin
          tail_one++;
          words[tail_one] = op.value;
        end
      end
      KIND_POP_ONE: begin
        if (empty_one) begin
          res.result_value = RESULT_EMPTY;
          res.status = ST_EMPTY;
        end else begin
          res.result_value = words[head_one];
          if (head_one == tail_one) begin
            head_one = 0;
            tail_one = 0;
            empty_one = 1'b1;
          end else begin
            head_one++;
          end
        end
      end
      KIND_PUSH_TWO: begin
        if (empty_two) begin
          head_two = 2 * cap - 1;
          tail_two = head_two;
          empty_two = 1'b0;
          words[head_two] = op.value;
        end else if (tail_two <= cap) begin
          res.status = ST_FULL;
        end else begin
          tail_two--;
          words[tail_two] = op.value;
        end
      end
      default: begin
        if (empty_two) begin
          res.result_value = RESULT_EMPTY;
          res.status = ST_EMPTY;
        end else begin
          res.result_value = words[head_two];
          if (head_two == tail_two) begin
            head_two = 0;
            tail_two = 0;
            empty_two = 1'b1;
          end else begin
            head_two--;
          end
        end
      end
    endcase
    pending_results.push_back(res);
  endfunction

  function void check_result(out_beat_t got);
    out_beat_t want;
    if (pending_results.size() == 0) begin
      if (mismatches < 10)
        $display("Unexpected result beat: value %h status %0d", got.result_value, got.status);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.result_value !== want.result_value || got.status !== want.status) begin
      if (mismatches < 10)
        $display("Result mismatch: expected value %h status %0d, got value %h status %0d",
                 want.result_value, want.status, got.result_value, got.status);
      mismatches++;
    end
  endfunction
endclass

module tb;
  logic clk = 1'b0;
  logic rst_n;
  logic hold_off = 1'b0;
  bit   hold_go = 1'b0;

  dlq_scoreboard sb = new();

  dlq_chan_if #(.payload_t(in_beat_t))  in_ch ();
  dlq_chan_if #(.payload_t(out_beat_t)) out_ch ();
  dlq_chan_if #(.payload_t(cfg_beat_t)) cfg_ch ();

  dual_linear_queue_shared_buffer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  task automatic send_op(input kind_t k, input logic [DATA_W-1:0] v);
    in_beat_t op;
    op.kind = k;
    op.value = v;
    in_ch.valid <= 1'b1;
    in_ch.data <= op;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_op(op);
  endtask

  task automatic write_size(input logic [QSIZE_W-1:0] sz);
    cfg_beat_t beat;
    beat.queue_size = sz;
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= beat;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.qsize = sz;
  endtask

  task automatic run_phase(input int n_items, input int gap_max);
    int               burst_left;
    int               push_pct;
    int               flip_left;
    bit               to_two;
    bit               is_pop;
    logic [DATA_W-1:0] v;
    burst_left = $urandom_range(1, 24);
    push_pct = 75;
    flip_left = $urandom_range(16, 48);
    for (int i = 0; i < n_items; i++) begin
      if (flip_left == 0) begin
        push_pct = 100 - push_pct;
        flip_left = $urandom_range(16, 48);
      end
      flip_left--;
      to_two = $urandom_range(0, 1);
      is_pop = ($urandom_range(0, 99) >= push_pct);
      case ($urandom_range(0, 9))
        0: v = 32'h8000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = '1;
        3: v = '0;
        default: v = $urandom;
      endcase
      send_op(kind_t'({to_two, is_pop}), v);
      if (gap_max > 0) begin
        burst_left--;
        if (burst_left == 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, gap_max)) @(posedge clk);
          burst_left = $urandom_range(1, 24);
        end
      end
    end
  endtask

  initial begin : result_sink
    int cyc;
    bit rdy;
    cyc = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      cyc++;
      case ((cyc >> 9) % 4)
        0: rdy = 1'b1;
        1: rdy = $urandom_range(0, 1);
        2: rdy = (cyc % 3 == 0);
        default: rdy = ($urandom_range(0, 9) != 0);
      endcase
      out_ch.ready <= rdy && !hold_off;
    end
  end

  initial begin : squeeze
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    logic [QSIZE_W-1:0] phase_sizes [10] = '{7'd64, 7'd1, 7'd3, 7'd127, 7'd5,
                                             7'd8, 7'd2, 7'd100, 7'd16, 7'd4};
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_size(7'd2);
    send_op(KIND_POP_ONE, 32'h1234_5678);
    send_op(KIND_POP_TWO, 32'h0);
    send_op(KIND_PUSH_ONE, 32'h7FFF_FFFF);
    send_op(KIND_PUSH_ONE, 32'h8000_0000);
    send_op(KIND_PUSH_ONE, 32'h0);
    send_op(KIND_PUSH_TWO, 32'hFFFF_FFFF);
    send_op(KIND_PUSH_TWO, 32'h0);
    send_op(KIND_PUSH_TWO, 32'h5);
    send_op(KIND_POP_ONE, 32'hFFFF_FFFF);
    // A linear queue does not reclaim the popped slot until it drains.
    send_op(KIND_PUSH_ONE, 32'h3);
    send_op(KIND_POP_ONE, 32'h0);
    send_op(KIND_POP_ONE, 32'h0);
    send_op(KIND_POP_TWO, 32'h0);
    send_op(KIND_POP_TWO, 32'h0);
    send_op(KIND_POP_TWO, 32'h0);
    send_op(KIND_PUSH_TWO, 32'h0F0F_0F0F);
    send_op(KIND_PUSH_ONE, 32'h5555_5555);

    // Shrink the size while both queues hold data.
    write_size(7'd0);
    send_op(KIND_PUSH_TWO, 32'hF0F0_F0F0);
    send_op(KIND_PUSH_TWO, 32'h0000_0001);
    send_op(KIND_PUSH_TWO, 32'hAAAA_AAAA);
    send_op(KIND_PUSH_ONE, 32'hAAAA_AAAA);
    send_op(KIND_POP_TWO, 32'h0);
    send_op(KIND_POP_TWO, 32'h0);
    send_op(KIND_POP_TWO, 32'h0);
    send_op(KIND_POP_ONE, 32'h0);

    for (int p = 0; p < 10; p++) begin
      write_size(phase_sizes[p]);
      if (p == 2) hold_go = 1'b1;
      run_phase(175, (p % 3 == 2) ? 0 : 4);
    end

    in_ch.valid <= 1'b0;
    for (int i = 0; i < 50000 && sb.pending_results.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.mismatches += sb.pending_results.size();
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
